@@ rtl/rlcs_pkg.sv @@
// shared constants, types and helpers of the rgb led chain serializer
package rlcs_pkg;

   localparam int PIXELS = 16;
   localparam int PIX_W  = $clog2(PIXELS);
   localparam int ROW_W  = 24;

   // item function codes
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_SET   = 2'd1;
   localparam logic [1:0] FUNC_START = 2'd2;

   // register indexes
   localparam logic [2:0] REG_ONE_HIGH  = 3'd0;
   localparam logic [2:0] REG_ZERO_HIGH = 3'd1;
   localparam logic [2:0] REG_BIT_TICKS = 3'd2;
   localparam logic [2:0] REG_LATCH     = 3'd3;
   localparam logic [2:0] REG_PIX_COUNT = 3'd4;

   localparam logic [7:0]  ONE_HIGH_RST  = 8'd13;
   localparam logic [7:0]  ZERO_HIGH_RST = 8'd6;
   localparam logic [7:0]  BIT_TICKS_RST = 8'd20;
   localparam logic [15:0] LATCH_RST     = 16'd800;
   localparam logic [4:0]  PIX_COUNT_RST = 5'd15;

   // color order within a row: green, red, blue
   localparam logic [1:0] COL_GREEN = 2'd0;
   localparam logic [1:0] COL_RED   = 2'd1;
   localparam logic [1:0] COL_BLUE  = 2'd2;

   typedef struct packed {
      logic [7:0]  one_high;
      logic [7:0]  zero_high;
      logic [7:0]  bit_ticks;
      logic [15:0] latch;
      logic [4:0]  pixel_count;
   } cfg_type;

   typedef struct packed {
      logic             en;
      logic [PIX_W-1:0] addr;
      logic [ROW_W-1:0] row;
   } wr_type;

   typedef struct packed {
      logic line_level;
      logic busy_res;
   } rsp_data_type;

   // pixel_count limited to the store size
   function automatic logic [4:0] active_pixels(input logic [4:0] count);
      logic [4:0] lim;
      lim = 5'(PIXELS);
      return (count < lim) ? count : lim;
   endfunction

   function automatic logic [7:0] row_byte(input logic [ROW_W-1:0] row,
                                           input logic [1:0] col);
      logic [7:0] b;
      case (col)
         COL_GREEN: b = row[23:16];
         COL_RED:   b = row[15:8];
         default:   b = row[7:0];
      endcase
      return b;
   endfunction

endpackage

@@ rtl/rlcs_req_if.sv @@
// request channel: one item per beat
interface rlcs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] func;
   logic [7:0] pixel;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;

   modport source (output valid, func, pixel, red, green, blue, input ready);
   modport sink   (input valid, func, pixel, red, green, blue, output ready);
endinterface

@@ rtl/rlcs_rsp_if.sv @@
// response channel: one result per beat
interface rlcs_rsp_if;
   logic valid;
   logic ready;
   logic line_level;
   logic busy_res;

   modport source (output valid, line_level, busy_res, input ready);
   modport sink   (input valid, line_level, busy_res, output ready);
endinterface

@@ rtl/rlcs_store.sv @@
// pixel color store: one green/red/blue row per pixel
module rlcs_store
   import rlcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  wr_type           wr,
   input  logic [PIX_W-1:0] rd_addr,
   output logic [ROW_W-1:0] rd_row
);

   logic [ROW_W-1:0] rows_ff [PIXELS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIXELS; i++) begin
            rows_ff[i] <= '0;
         end
      end else if (wr.en) begin
         rows_ff[wr.addr] <= wr.row;
      end
   end

   assign rd_row = rows_ff[rd_addr];

endmodule

@@ rtl/rlcs_engine.sv @@
// frame sequencer and bit timing of the serial line
module rlcs_engine
   import rlcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             tick,
   input  logic             start,
   input  cfg_type          cfg,
   output logic [PIX_W-1:0] rd_addr,
   input  logic [ROW_W-1:0] rd_row,
   output logic             tick_level,
   output logic             cur_level,
   output logic             busy
);

   logic             sending_ff, sending_in;
   logic             pending_ff, pending_in;
   logic [15:0]      gap_ff, gap_in;
   logic [7:0]       tick_ff, tick_in;
   logic [2:0]       bit_ff, bit_in;
   logic [PIX_W-1:0] pix_ff, pix_in;
   logic [1:0]       col_ff, col_in;
   logic [7:0]       shift_ff, shift_in;

   logic [4:0]       active;
   logic             start_frame;
   logic             run;
   logic [7:0]       w_shift;
   logic [7:0]       span;
   logic [8:0]       tick_next;
   logic [6:0]       next_byte;
   logic [6:0]       byte_lim;
   logic [PIX_W-1:0] pix_adv;
   logic [1:0]       col_adv;

   assign active = active_pixels(cfg.pixel_count);
   assign start_frame = tick && !sending_ff && (gap_ff == '0) && pending_ff
                        && (active != '0);
   assign span = (cfg.bit_ticks == '0) ? 8'd1 : cfg.bit_ticks;
   assign cur_level = sending_ff &&
                      (tick_ff < (shift_ff[7] ? cfg.one_high : cfg.zero_high));

   // position of the byte after the current one
   assign col_adv = (col_ff == COL_BLUE) ? COL_GREEN : col_ff + 2'd1;
   assign pix_adv = (col_ff == COL_BLUE) ? pix_ff + PIX_W'(1) : pix_ff;
   assign next_byte = 7'({pix_ff, 1'b0}) + 7'(pix_ff) + 7'(col_ff) + 7'd1;
   assign byte_lim = 7'({active, 1'b0}) + 7'(active);

   // a new frame always reads row zero; a frame never starts and ends a byte at once
   assign rd_addr = start_frame ? '0 : pix_adv;

   always_comb begin
      sending_in = sending_ff;
      pending_in = pending_ff | start;
      gap_in     = gap_ff;
      tick_in    = tick_ff;
      bit_in     = bit_ff;
      pix_in     = pix_ff;
      col_in     = col_ff;
      shift_in   = shift_ff;
      run        = 1'b0;
      w_shift    = shift_ff;
      tick_level = 1'b0;
      tick_next  = {1'b0, tick_ff} + 9'd1;

      if (tick) begin
         if (sending_ff) begin
            run = 1'b1;
         end else if (gap_ff != '0) begin
            gap_in = gap_ff - 16'd1;
         end else if (pending_ff) begin
            pending_in = 1'b0;
            if (active == '0) begin
               gap_in = cfg.latch;
            end else begin
               run        = 1'b1;
               sending_in = 1'b1;
               w_shift    = row_byte(rd_row, COL_GREEN);
            end
         end
      end

      if (run) begin
         tick_level = tick_ff < (w_shift[7] ? cfg.one_high : cfg.zero_high);
         if (tick_next < {1'b0, span}) begin
            tick_in  = tick_next[7:0];
            shift_in = w_shift;
         end else begin
            tick_in  = '0;
            shift_in = {w_shift[6:0], 1'b0};
            if (bit_ff != 3'd7) begin
               bit_in = bit_ff + 3'd1;
            end else begin
               bit_in = '0;
               if (next_byte >= byte_lim) begin
                  sending_in = 1'b0;
                  pix_in     = '0;
                  col_in     = COL_GREEN;
                  gap_in     = cfg.latch;
               end else begin
                  pix_in   = pix_adv;
                  col_in   = col_adv;
                  shift_in = row_byte(rd_row, col_adv);
               end
            end
         end
      end
   end

   assign busy = sending_in || pending_in || (gap_in != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         sending_ff <= 1'b0;
         pending_ff <= 1'b0;
         gap_ff     <= '0;
         tick_ff    <= '0;
         bit_ff     <= '0;
         pix_ff     <= '0;
         col_ff     <= COL_GREEN;
         shift_ff   <= '0;
      end else begin
         sending_ff <= sending_in;
         pending_ff <= pending_in;
         gap_ff     <= gap_in;
         tick_ff    <= tick_in;
         bit_ff     <= bit_in;
         pix_ff     <= pix_in;
         col_ff     <= col_in;
         shift_ff   <= shift_in;
      end
   end

`ifndef SYNTHESIS
   a_no_gap_while_sending: assert property (@(posedge clock) disable iff (reset)
      sending_ff |-> gap_ff == '0)
      else $error("latch gap counting during a frame");

   a_idle_position_cleared: assert property (@(posedge clock) disable iff (reset)
      !sending_ff |-> (tick_ff == '0 && bit_ff == '0 && pix_ff == '0
                       && col_ff == COL_GREEN))
      else $error("bit position not cleared outside a frame");

   a_frame_needs_request: assert property (@(posedge clock) disable iff (reset)
      $rose(sending_ff) |-> $past(pending_ff) && !pending_ff)
      else $error("frame began without a pending start");
`endif

endmodule

@@ rtl/rgb_led_chain_serializer.sv @@
// Single-wire RGB pixel chain driver. Every request beat is handled in the
// clock cycle it is accepted: a tick advances the line waveform by one time
// unit, a set writes a pixel row, a start requests a frame, and each beat
// yields exactly one response beat with the line level and the busy flag.
// One item is taken per clock while the response buffer is not full; the
// limit is the single pass through the bit-timing and sequencing logic,
// which reads the 16-row color register file combinationally. Responses wait
// in a two-entry buffer, so requests keep flowing while one response is held
// back. Registers may be written whenever no beat is in flight.
module rgb_led_chain_serializer
   import rlcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   rlcs_req_if.sink    req_chan,
   rlcs_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   cfg_type          cfg_ff;
   wr_type           wr;
   logic             req_fire;
   logic             rsp_fire;
   logic             is_tick;
   logic             is_start;
   logic [PIX_W-1:0] rd_addr;
   logic [ROW_W-1:0] rd_row;
   logic             tick_level;
   logic             cur_level;
   logic             busy;
   rsp_data_type     new_rsp;

   logic [1:0]       cnt_ff, cnt_in;
   rsp_data_type     slot0_ff, slot0_in;
   rsp_data_type     slot1_ff, slot1_in;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_high    <= ONE_HIGH_RST;
         cfg_ff.zero_high   <= ZERO_HIGH_RST;
         cfg_ff.bit_ticks   <= BIT_TICKS_RST;
         cfg_ff.latch       <= LATCH_RST;
         cfg_ff.pixel_count <= PIX_COUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            REG_ONE_HIGH:  cfg_ff.one_high    <= csr_wdata[7:0];
            REG_ZERO_HIGH: cfg_ff.zero_high   <= csr_wdata[7:0];
            REG_BIT_TICKS: cfg_ff.bit_ticks   <= csr_wdata[7:0];
            REG_LATCH:     cfg_ff.latch       <= csr_wdata;
            REG_PIX_COUNT: cfg_ff.pixel_count <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   assign req_chan.ready = (cnt_ff != 2'd2);
   assign req_fire = req_chan.valid && req_chan.ready;
   assign is_tick  = req_fire && (req_chan.func == FUNC_TICK);
   assign is_start = req_fire && (req_chan.func == FUNC_START);

   assign wr.en   = req_fire && (req_chan.func == FUNC_SET)
                    && (req_chan.pixel < {3'b000, active_pixels(cfg_ff.pixel_count)});
   assign wr.addr = req_chan.pixel[PIX_W-1:0];
   assign wr.row  = {req_chan.green, req_chan.red, req_chan.blue};

   rlcs_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_row  (rd_row)
   );

   rlcs_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .tick       (is_tick),
      .start      (is_start),
      .cfg        (cfg_ff),
      .rd_addr    (rd_addr),
      .rd_row     (rd_row),
      .tick_level (tick_level),
      .cur_level  (cur_level),
      .busy       (busy)
   );

   assign new_rsp.line_level = is_tick ? tick_level : cur_level;
   assign new_rsp.busy_res   = busy;

   // two-entry response buffer, slot0 is the head
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;

   always_comb begin
      cnt_in   = cnt_ff + {1'b0, req_fire} - {1'b0, rsp_fire};
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      if (rsp_fire) begin
         if (cnt_ff == 2'd2) begin
            slot0_in = slot1_ff;
         end else begin
            slot0_in = new_rsp;
         end
      end else if (cnt_ff == 2'd0) begin
         slot0_in = new_rsp;
      end
      if (req_fire && (((cnt_ff == 2'd1) && !rsp_fire) ||
                       ((cnt_ff == 2'd2) && rsp_fire))) begin
         slot1_in = new_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

   assign rsp_chan.valid      = (cnt_ff != 2'd0);
   assign rsp_chan.line_level = slot0_ff.line_level;
   assign rsp_chan.busy_res   = slot0_ff.busy_res;

`ifndef SYNTHESIS
   a_buffer_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("response buffer overfilled");

   a_drain_order: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd2 && rsp_fire) |=> slot0_ff == $past(slot1_ff))
      else $error("response buffer lost its order");

   a_no_take_when_full: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !req_fire)
      else $error("request taken with no room for its response");
`endif

endmodule
